// File: sv/wrc_pkg.sv
// ----------------------------------------------------------------------------
// wrc_pkg: shared constants and helpers for the wall raycast pixel shader
// Fixed-point limits, sequencer codes, register indexes and the shade ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package wrc_pkg;

    // Geometry
    localparam int MAX_WALLS   = 8;
    localparam int HALF_SCREEN = 32;
    localparam int SLOT_W      = 3;
    localparam int CNT_W       = 4;

    // Quotient bits of the depth divider (hit depth stays below 2^22)
    localparam int DIV_BITS = 22;

    // Scaled distance limits: 10000 in Q23.8, and its square times 2^16*h^2
    localparam logic [30:0] S_FAR   = 31'd2560000;
    localparam logic [55:0] LHS_FAR = 56'd6710886400000000;
    localparam logic [21:0] S_SHADE = 22'd32768;

    // Register indexes
    localparam logic [2:0] REG_CAM_X  = 3'd0;
    localparam logic [2:0] REG_CAM_Y  = 3'd1;
    localparam logic [2:0] REG_COS    = 3'd2;
    localparam logic [2:0] REG_SIN    = 3'd3;
    localparam logic [2:0] REG_ACTIVE = 3'd4;
    localparam logic [2:0] REG_SCALE  = 3'd5;

    // Input modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // Per-wall steps of the shared multiplier
    localparam logic [4:0] STP_CDX_S = 5'd0;
    localparam logic [4:0] STP_SDY_S = 5'd1;
    localparam logic [4:0] STP_SDX_S = 5'd2;
    localparam logic [4:0] STP_CDY_S = 5'd3;
    localparam logic [4:0] STP_CDX_E = 5'd4;
    localparam logic [4:0] STP_SDY_E = 5'd5;
    localparam logic [4:0] STP_SDX_E = 5'd6;
    localparam logic [4:0] STP_CDY_E = 5'd7;
    localparam logic [4:0] STP_EW    = 5'd8;
    localparam logic [4:0] STP_DEN   = 5'd9;
    localparam logic [4:0] STP_NUM   = 5'd10;
    localparam logic [4:0] STP_ZN0   = 5'd11;
    localparam logic [4:0] STP_ZN1   = 5'd12;
    localparam logic [4:0] STP_ZN    = 5'd13;
    localparam logic [4:0] STP_HT0   = 5'd14;
    localparam logic [4:0] STP_HT1   = 5'd15;
    localparam logic [4:0] STP_HT    = 5'd16;
    localparam logic [4:0] STP_SCL   = 5'd17;
    localparam logic [4:0] STP_RAD   = 5'd18;
    localparam logic [4:0] STP_SQ    = 5'd19;
    localparam logic [4:0] STP_CMP   = 5'd20;

    localparam logic [6:0] GLYPH_BLANK = 7'h20;

    // Shade ramp, darkest first
    function automatic logic [6:0] ramp_glyph(input logic [2:0] shade);
        logic [6:0] g;
        begin
            case (shade)
                3'd0:    g = 7'h20;
                3'd1:    g = 7'h2E;
                3'd2:    g = 7'h3A;
                3'd3:    g = 7'h2B;
                3'd4:    g = 7'h3D;
                3'd5:    g = 7'h25;
                3'd6:    g = 7'h23;
                3'd7:    g = 7'h40;
                default: g = 7'h20;
            endcase
            return g;
        end
    endfunction

    // Count thresholds 2^(41-2k), k = 1..7, that the squared distance meets
    function automatic logic [2:0] shade_of(input logic [55:0] lhs);
        logic [2:0] cnt;
        begin
            cnt = 3'd0;
            for (int k = 1; k <= 7; k++)
            begin
                if (lhs <= (56'd1 << (41 - 2 * k)))
                begin
                    cnt = cnt + 3'd1;
                end
            end
            return cnt;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/wall_raycast_pixel_shader_unit.sv
// ----------------------------------------------------------------------------
// wall_raycast_pixel_shader_unit: ray / wall-segment raycasting pixel shader
// Holds an eight-entry wall table and shades one pixel per render request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): mode 0 writes a wall segment into
//   entry wall_slot in the accepting cycle and gives no result. Mode 1
//   renders pixel (pixel_col, pixel_row) and gives one result on the output
//   channel (out_valid / out_stall): glyph, shade, hit and nearest_wall.
//   Configuration (cfg_valid / cfg_ready, always ready) sets camera position,
//   rotation, the number of active walls and the depth scale; write it only
//   while no render is in flight.
//   Sequencing: per active wall a render runs up to 21 steps of the one
//   shared 35x29 multiplier and 22 steps of the radix-2 depth divider;
//   walls rejected early take fewer steps. in_stall is high for the whole
//   of a render.
//   The result sits in an output register: the next request is taken while
//   it waits, and a render that finishes while it is still stalled holds
//   until it is taken.
//   Reset clears configuration to its defaults and empties the output; the
//   wall table is not cleared and must be written before it is used.
`default_nettype none

module wall_raycast_pixel_shader_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    // request channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               mode,
    input  wire logic [2:0]         wall_slot,
    input  wire logic signed [15:0] start_x,
    input  wire logic signed [15:0] start_y,
    input  wire logic signed [15:0] end_x,
    input  wire logic signed [15:0] end_y,
    input  wire logic [5:0]         pixel_col,
    input  wire logic [5:0]         pixel_row,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [6:0]              glyph,
    output logic [2:0]              shade,
    output logic                    hit,
    output logic [2:0]              nearest_wall
);

    // Configuration
    logic signed [15:0] cam_x_reg, cam_x_next, cam_y_reg, cam_y_next;
    logic signed [15:0] cos_reg, cos_next, sin_reg, sin_next;
    logic [3:0]         act_reg, act_next;
    logic [7:0]         scale_reg, scale_next;

    // Sequencer
    logic [1:0]  state_reg, state_next;
    logic [4:0]  step_reg, step_next;
    logic [4:0]  div_cnt_reg, div_cnt_next;
    logic [wrc_pkg::SLOT_W-1:0] widx_reg, widx_next;

    // Pixel
    logic signed [6:0] pa_reg, pa_next;
    logic [5:0]        babs_reg, babs_next;
    logic [11:0]       radial_reg, radial_next;

    // Datapath
    logic signed [63:0] prod_reg;
    logic signed [47:0] acc_reg, acc_next;
    logic signed [19:0] sz_reg, sz_next, sw_reg, sw_next, ez_reg, ez_next, ew_reg, ew_next;
    logic signed [27:0] dtmp_reg, dtmp_next, num_reg, num_next;
    logic [27:0]        den_reg, den_next;
    logic signed [47:0] zn_reg, zn_next;
    logic [29:0]        rem_reg, rem_next;
    logic [21:0]        q_reg, q_next;
    logic [21:0]        s_reg, s_next;

    // Nearest hit
    logic               found_reg, found_next;
    logic [21:0]        best_zq_reg, best_zq_next;
    logic [2:0]         best_slot_reg, best_slot_next;
    logic [21:0]        best_s_reg, best_s_next;
    logic [55:0]        best_lhs_reg, best_lhs_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [6:0]         glyph_reg;
    logic [2:0]         shade_reg;
    logic               hit_reg;
    logic [2:0]         nwall_reg;
    logic               out_load;

    // Wall table
    logic [63:0]        wall_tbl_reg [wrc_pkg::MAX_WALLS];
    logic [63:0]        entry;

    logic               in_acc;
    logic [3:0]         n_walls;
    logic signed [16:0] dxs, dys, dxe, dye;
    logic signed [20:0] dz, dw;
    logic signed [34:0] mul_a;
    logic signed [28:0] mul_b;
    logic signed [34:0] rot_sum;
    logic signed [34:0] rot_rnd;
    logic signed [27:0] den_raw, num_raw, den_abs, num_abs;
    logic signed [47:0] zn_sum;
    logic [53:0]        hgt, hgt_lim;
    logic [48:0]        dvd;
    logic [30:0]        div_cat, div_trial;
    logic [28:0]        divisor;
    logic [2:0]         shade_calc;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != wrc_pkg::ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign n_walls   = (act_reg > 4'(wrc_pkg::MAX_WALLS)) ? 4'(wrc_pkg::MAX_WALLS) : act_reg;

    // Camera-relative endpoints of the current wall
    assign entry = wall_tbl_reg[widx_reg];
    assign dxs = {entry[15], entry[15:0]}   - {cam_x_reg[15], cam_x_reg};
    assign dys = {entry[31], entry[31:16]}  - {cam_y_reg[15], cam_y_reg};
    assign dxe = {entry[47], entry[47:32]}  - {cam_x_reg[15], cam_x_reg};
    assign dye = {entry[63], entry[63:48]}  - {cam_y_reg[15], cam_y_reg};
    assign dz  = {ez_reg[19], ez_reg} - {sz_reg[19], sz_reg};
    assign dw  = {ew_reg[19], ew_reg} - {sw_reg[19], sw_reg};

    // Select multiplier operands for this step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == wrc_pkg::ST_WALL)
        begin
            case (step_reg)
                wrc_pkg::STP_CDX_S: begin mul_a = 35'(dxs); mul_b = 29'(cos_reg); end
                wrc_pkg::STP_SDY_S: begin mul_a = 35'(dys); mul_b = 29'(sin_reg); end
                wrc_pkg::STP_SDX_S: begin mul_a = 35'(dxs); mul_b = 29'(sin_reg); end
                wrc_pkg::STP_CDY_S: begin mul_a = 35'(dys); mul_b = 29'(cos_reg); end
                wrc_pkg::STP_CDX_E: begin mul_a = 35'(dxe); mul_b = 29'(cos_reg); end
                wrc_pkg::STP_SDY_E: begin mul_a = 35'(dye); mul_b = 29'(sin_reg); end
                wrc_pkg::STP_SDX_E: begin mul_a = 35'(dxe); mul_b = 29'(sin_reg); end
                wrc_pkg::STP_CDY_E: begin mul_a = 35'(dye); mul_b = 29'(cos_reg); end
                wrc_pkg::STP_EW:    begin mul_a = 35'(dz);     mul_b = 29'(pa_reg); end
                wrc_pkg::STP_DEN:   begin mul_a = 35'(sz_reg); mul_b = 29'(pa_reg); end
                wrc_pkg::STP_ZN0:   begin mul_a = {7'd0, den_reg}; mul_b = 29'(sz_reg); end
                wrc_pkg::STP_ZN1:   begin mul_a = 35'(num_reg);    mul_b = 29'(dz); end
                wrc_pkg::STP_HT0:   begin mul_a = {10'd0, zn_reg[24:0]}; mul_b = {23'd0, babs_reg}; end
                wrc_pkg::STP_HT1:   begin mul_a = {12'd0, zn_reg[47:25]}; mul_b = {23'd0, babs_reg}; end
                wrc_pkg::STP_SCL:   begin mul_a = {13'd0, q_reg}; mul_b = {21'd0, scale_reg}; end
                wrc_pkg::STP_RAD:   begin mul_a = {13'd0, prod_reg[21:0]}; mul_b = {17'd0, radial_reg}; end
                wrc_pkg::STP_SQ:    begin mul_a = prod_reg[34:0]; mul_b = {7'd0, s_reg}; end
                default:            begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    // Shared multiplier, registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    // Rotation: round half up of (acc -/+ product) / 2^14
    always_comb
    begin
        if (step_reg inside {wrc_pkg::STP_SDX_S, wrc_pkg::STP_SDX_E})
        begin
            rot_sum = acc_reg[34:0] - prod_reg[34:0];
        end
        else
        begin
            rot_sum = acc_reg[34:0] + prod_reg[34:0];
        end
        rot_rnd = (rot_sum + 35'sd8192) >>> 14;
    end

    // Intersection terms
    assign den_raw = {{2{dw[20]}}, dw, 5'd0} - prod_reg[27:0];
    assign num_raw = prod_reg[27:0] - {{3{sw_reg[19]}}, sw_reg, 5'd0};
    assign den_abs = dtmp_reg[27] ? -dtmp_reg : dtmp_reg;
    assign num_abs = dtmp_reg[27] ? -num_raw : num_raw;
    assign zn_sum  = acc_reg + prod_reg[47:0];
    assign hgt     = {1'b0, prod_reg[27:0], 25'd0} + {23'd0, acc_reg[30:0]};
    assign hgt_lim = {13'd0, den_reg, 13'd0};

    // Restoring divider for round(zn / den), computed as (2zn + den) / 2den
    assign dvd       = {zn_reg, 1'b0} + {21'd0, den_reg};
    assign divisor   = {den_reg, 1'b0};
    assign div_cat   = {rem_reg, q_reg[21]};
    assign div_trial = div_cat - {2'd0, divisor};

    assign shade_calc = (found_reg && best_s_reg < wrc_pkg::S_SHADE)
                        ? wrc_pkg::shade_of(best_lhs_reg) : 3'd0;

    // Next-state logic
    always_comb
    begin
        cam_x_next = cam_x_reg;   cam_y_next = cam_y_reg;
        cos_next   = cos_reg;     sin_next   = sin_reg;
        act_next   = act_reg;     scale_next = scale_reg;
        state_next = state_reg;   step_next  = step_reg;
        div_cnt_next = div_cnt_reg;
        widx_next  = widx_reg;
        pa_next    = pa_reg;      babs_next  = babs_reg;   radial_next = radial_reg;
        acc_next   = acc_reg;
        sz_next = sz_reg; sw_next = sw_reg; ez_next = ez_reg; ew_next = ew_reg;
        dtmp_next  = dtmp_reg;    num_next = num_reg;      den_next = den_reg;
        zn_next    = zn_reg;      rem_next = rem_reg;      q_next   = q_reg;
        s_next     = s_reg;
        found_next = found_reg;   best_zq_next = best_zq_reg;
        best_slot_next = best_slot_reg;
        best_s_next = best_s_reg; best_lhs_next = best_lhs_reg;
        out_load   = 1'b0;

        // Register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                wrc_pkg::REG_CAM_X:  cam_x_next = cfg_data;
                wrc_pkg::REG_CAM_Y:  cam_y_next = cfg_data;
                wrc_pkg::REG_COS:    cos_next   = cfg_data;
                wrc_pkg::REG_SIN:    sin_next   = cfg_data;
                wrc_pkg::REG_ACTIVE: act_next   = cfg_data[3:0];
                wrc_pkg::REG_SCALE:  scale_next = cfg_data[7:0];
                default: ;
            endcase
        end

        case (state_reg)
            wrc_pkg::ST_IDLE:
            begin
                // Start a render; wall writes go straight to the table
                if (in_acc && mode == wrc_pkg::MODE_RENDER)
                begin
                    pa_next     = $signed({1'b0, pixel_col}) - 7'sd32;
                    babs_next   = (pixel_row <= 6'd32) ? (6'd32 - pixel_row)
                                                       : (pixel_row - 6'd32);
                    radial_next = 12'd1024 + 12'(($signed({1'b0, pixel_col}) - 7'sd32)
                                              * ($signed({1'b0, pixel_col}) - 7'sd32));
                    found_next  = 1'b0;
                    best_slot_next = '0;
                    widx_next   = '0;
                    step_next   = wrc_pkg::STP_CDX_S;
                    state_next  = (n_walls == 4'd0) ? wrc_pkg::ST_OUT : wrc_pkg::ST_WALL;
                end
            end
            wrc_pkg::ST_WALL:
            begin
                step_next = step_reg + 5'd1;
                case (step_reg)
                    wrc_pkg::STP_SDY_S, wrc_pkg::STP_CDY_S,
                    wrc_pkg::STP_SDY_E, wrc_pkg::STP_CDY_E,
                    wrc_pkg::STP_ZN1, wrc_pkg::STP_HT1:
                        acc_next = prod_reg[47:0];
                    wrc_pkg::STP_SDX_S: sz_next = rot_rnd[19:0];
                    wrc_pkg::STP_CDX_E: sw_next = rot_rnd[19:0];
                    wrc_pkg::STP_SDX_E: ez_next = rot_rnd[19:0];
                    wrc_pkg::STP_EW:    ew_next = rot_rnd[19:0];
                    wrc_pkg::STP_DEN:   dtmp_next = den_raw;
                    wrc_pkg::STP_NUM:
                    begin
                        den_next = den_abs;
                        num_next = num_abs;
                        // drop parallel walls and misses off the segment
                        if (dtmp_reg == 28'sd0 || num_abs < 28'sd0 || num_abs > den_abs)
                        begin
                            step_next = wrc_pkg::STP_CMP;
                        end
                    end
                    wrc_pkg::STP_ZN:
                    begin
                        zn_next = zn_sum;
                        if (zn_sum < 48'sd0)
                        begin
                            step_next = wrc_pkg::STP_CMP;
                        end
                    end
                    wrc_pkg::STP_HT:
                    begin
                        if (hgt > hgt_lim)
                        begin
                            step_next = wrc_pkg::STP_CMP;
                        end
                        else
                        begin
                            rem_next     = {3'd0, dvd[48:22]};
                            q_next       = dvd[21:0];
                            div_cnt_next = '0;
                            state_next   = wrc_pkg::ST_DIV;
                        end
                    end
                    wrc_pkg::STP_RAD:
                    begin
                        s_next = prod_reg[21:0];
                        if (prod_reg[30:0] >= wrc_pkg::S_FAR)
                        begin
                            step_next = wrc_pkg::STP_CMP;
                        end
                    end
                    default: ;
                endcase

                // Pick up a hit, then advance to the next wall
                if (step_next == wrc_pkg::STP_CMP && step_reg == wrc_pkg::STP_CMP)
                begin
                    step_next = wrc_pkg::STP_CMP;
                end
                if (step_reg == wrc_pkg::STP_CMP ||
                    (step_next == wrc_pkg::STP_CMP && step_reg != wrc_pkg::STP_SQ))
                begin
                    if (step_reg == wrc_pkg::STP_CMP && prod_reg[55:0] < wrc_pkg::LHS_FAR
                        && prod_reg[63:56] == 8'd0 && (!found_reg || q_reg < best_zq_reg))
                    begin
                        found_next     = 1'b1;
                        best_zq_next   = q_reg;
                        best_slot_next = widx_reg;
                        best_s_next    = s_reg;
                        best_lhs_next  = prod_reg[55:0];
                    end
                    step_next = wrc_pkg::STP_CDX_S;
                    if ({1'b0, widx_reg} + 4'd1 == n_walls)
                    begin
                        state_next = wrc_pkg::ST_OUT;
                    end
                    else
                    begin
                        widx_next = widx_reg + 3'd1;
                    end
                end
            end
            wrc_pkg::ST_DIV:
            begin
                // One quotient bit per cycle
                if (div_cat >= {2'd0, divisor})
                begin
                    rem_next = div_trial[29:0];
                    q_next   = {q_reg[20:0], 1'b1};
                end
                else
                begin
                    rem_next = div_cat[29:0];
                    q_next   = {q_reg[20:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'(wrc_pkg::DIV_BITS - 1))
                begin
                    state_next = wrc_pkg::ST_WALL;
                    step_next  = wrc_pkg::STP_SCL;
                end
            end
            wrc_pkg::ST_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = wrc_pkg::ST_IDLE;
                end
            end
            default: state_next = wrc_pkg::ST_IDLE;
        endcase

        out_valid_next = (out_valid_reg && out_stall) || out_load;
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg     <= '0;
            cam_y_reg     <= '0;
            cos_reg       <= 16'sd16384;
            sin_reg       <= '0;
            act_reg       <= '0;
            scale_reg     <= 8'd25;
            state_reg     <= wrc_pkg::ST_IDLE;
            step_reg      <= wrc_pkg::STP_CDX_S;
            div_cnt_reg   <= '0;
            widx_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cam_x_reg     <= cam_x_next;
            cam_y_reg     <= cam_y_next;
            cos_reg       <= cos_next;
            sin_reg       <= sin_next;
            act_reg       <= act_next;
            scale_reg     <= scale_next;
            state_reg     <= state_next;
            step_reg      <= step_next;
            div_cnt_reg   <= div_cnt_next;
            widx_reg      <= widx_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pa_reg        <= pa_next;
        babs_reg      <= babs_next;
        radial_reg    <= radial_next;
        acc_reg       <= acc_next;
        sz_reg        <= sz_next;
        sw_reg        <= sw_next;
        ez_reg        <= ez_next;
        ew_reg        <= ew_next;
        dtmp_reg      <= dtmp_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        zn_reg        <= zn_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        s_reg         <= s_next;
        best_zq_reg   <= best_zq_next;
        best_slot_reg <= best_slot_next;
        best_s_reg    <= best_s_next;
        best_lhs_reg  <= best_lhs_next;
        if (out_load)
        begin
            shade_reg <= shade_calc;
            glyph_reg <= wrc_pkg::ramp_glyph(shade_calc);
            hit_reg   <= found_reg;
            nwall_reg <= found_reg ? best_slot_reg : 3'd0;
        end
    end

    // Wall table write
    always_ff @(posedge clk)
    begin
        if (in_acc && mode == wrc_pkg::MODE_WRITE)
        begin
            wall_tbl_reg[wall_slot] <= {end_y, end_x, start_y, start_x};
        end
    end

    assign out_valid    = out_valid_reg;
    assign glyph        = glyph_reg;
    assign shade        = shade_reg;
    assign hit          = hit_reg;
    assign nearest_wall = nwall_reg;

    // Checks
    a_miss_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (shade == 3'd0 && nearest_wall == 3'd0
                                 && glyph == wrc_pkg::GLYPH_BLANK))
        else $error("miss result not blank");

    a_glyph_shade: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (glyph == wrc_pkg::ramp_glyph(shade)))
        else $error("glyph does not match shade");

    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode == wrc_pkg::MODE_RENDER) |=> in_stall)
        else $error("render request did not start");

    a_wall_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wrc_pkg::ST_WALL) |-> ({1'b0, widx_reg} < n_walls))
        else $error("wall index beyond active walls");

    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wrc_pkg::ST_DIV) |-> (div_cnt_reg < 5'(wrc_pkg::DIV_BITS)))
        else $error("divider overran");

endmodule

`default_nettype wire
